@@ hdl/edge_blur_scale_stencil_assert.svh @@
// Assertion macros for the edge blur/scale stencil.
`ifndef EDGE_BLUR_SCALE_STENCIL_ASSERT_SVH
`define EDGE_BLUR_SCALE_STENCIL_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition a must be accompanied by condition b in the same cycle.
`define EBS_ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("edge_blur_scale_stencil: same-cycle check failed");

// Condition a must be followed by condition b in the next cycle.
`define EBS_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("edge_blur_scale_stencil: next-cycle check failed");

`else

`define EBS_ASSERT_SAME(label, clk, rst, a, b)
`define EBS_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

@@ hdl/ebs_pkg.sv @@
`default_nettype none

package ebs_pkg;

  // Store geometry
  localparam int MAX_POINTS   = 1024;
  localparam int SHOWN_POINTS = 10;
  localparam int ADDR_W       = $clog2(MAX_POINTS);
  localparam int COUNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SHOWN_W      = $clog2(SHOWN_POINTS + 1);

  // Fixed field widths
  localparam int DATA_W      = 32;
  localparam int ITER_W      = 16;
  localparam int INDEX_W     = 4;
  localparam int CFG_INDEX_W = 1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT  = 1'd1;

  localparam logic [DATA_W-1:0] SETTLE_THRESHOLD_RESET = 32'd21474836;
  localparam logic [ITER_W-1:0] ITERATION_LIMIT_RESET  = 16'd65535;

  // Reciprocals: floor(x/3) = (x*RECIP3) >> 33 for 32-bit x,
  // floor(x/9) = (x*RECIP9) >> 35 for 31-bit x.
  localparam logic [DATA_W-1:0] RECIP3       = 32'hAAAA_AAAB;
  localparam int                RECIP3_SHIFT = 33;
  localparam logic [DATA_W-1:0] RECIP9       = 32'd3817748708;
  localparam int                RECIP9_SHIFT = 35;
  // floor(2^32 / 3): weight of the carry word of a three-term sum
  localparam logic [DATA_W-1:0] DIV3_HI_UNIT = 32'd1431655765;

  // Band limits: floor(x/10) by reciprocal on values below 2^(COUNT_W+4)
  localparam int DIV10_S  = COUNT_W + 8;
  localparam int DIV10_M  = (2 ** DIV10_S + 9) / 10;
  localparam int DIV10_PW = COUNT_W + 4 + DIV10_S;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PRIME,
    ST_FETCH,
    ST_SUM,
    ST_DIV3,
    ST_FIX3,
    ST_MUL18,
    ST_FIX18,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  typedef enum logic {
    MUL_DIV3,
    MUL_DIV9
  } mul_op_t;

  typedef struct packed {
    logic              en;
    mul_op_t           op;
    logic [DATA_W-1:0] operand;
  } mul_req_t;

  // floor(rem * 11 / 18) for a remainder of a division by 18;
  // 11/18 taken as 627/1024, exact for remainders below 18
  function automatic logic [3:0] scale_rem(input logic [4:0] rem);
    return 4'((16'(rem) * 16'd627) >> 10);
  endfunction

endpackage

`default_nettype wire

@@ hdl/ebs_mul.sv @@
`default_nettype none

// Shared reciprocal multiplier: operand times the selected reciprocal,
// product registered.
module ebs_mul (
  input  logic                            clk,
  input  ebs_pkg::mul_req_t               req,
  output logic [2*ebs_pkg::DATA_W-1:0]    product
);

  logic [ebs_pkg::DATA_W-1:0] recip;

  // Pick the reciprocal
  always_comb begin
    case (req.op)
      ebs_pkg::MUL_DIV3: recip = ebs_pkg::RECIP3;
      ebs_pkg::MUL_DIV9: recip = ebs_pkg::RECIP9;
      default:           recip = ebs_pkg::RECIP3;
    endcase
  end

  // Register the product
  always_ff @(posedge clk) begin
    if (req.en) begin
      product <= {{ebs_pkg::DATA_W{1'b0}}, req.operand} *
                 {{ebs_pkg::DATA_W{1'b0}}, recip};
    end
  end

endmodule

`default_nettype wire

@@ hdl/edge_blur_scale_stencil.sv @@
`default_nettype none

// Edge blur/scale stencil. Samples load one per cycle while busy is low;
// the sample marked final_sample starts the run and busy rises on the next
// cycle. Every point of an iteration goes through the one shared reciprocal
// multiplier (once for a copy, twice for an average) and the single mesh
// read port; a setup state precedes the first iteration. The results then
// follow, min(N, 10) of them, each read in ST_EMIT_RD and then shown
// in ST_EMIT_OUT on the ports for one cycle under result_valid; the
// receiver cannot stall them, so it must take each one as it comes. busy
// falls in the cycle after the last result. The mesh store is not cleared
// after reset.
module edge_blur_scale_stencil (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ebs_pkg::DATA_W-1:0]          sample,
  input  logic                                final_sample,
  input  logic                                cfg_write,
  input  logic [ebs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ebs_pkg::DATA_W-1:0]          cfg_data,
  output logic                                result_valid,
  output logic [ebs_pkg::DATA_W-1:0]          point_value,
  output logic [ebs_pkg::INDEX_W-1:0]         point_index,
  output logic [ebs_pkg::ITER_W-1:0]          iterations_done,
  output logic                                converged,
  output logic                                final_point
);

  localparam int DW = ebs_pkg::DATA_W;
  localparam int AW = ebs_pkg::ADDR_W;
  localparam int CW = ebs_pkg::COUNT_W;
  localparam int SW = ebs_pkg::SHOWN_W;
  localparam int IW = ebs_pkg::ITER_W;

  ebs_pkg::state_t state, state_next;

  // Configuration
  logic [DW-1:0] settle_threshold;
  logic [IW-1:0] iteration_limit;

  // Run control
  logic [CW-1:0] point_count;
  logic [CW-1:0] n_pts;
  logic [CW-1:0] left_end;
  logic [CW-1:0] right_start;
  logic [SW-1:0] shown_last;
  logic [AW-1:0] idx;
  logic [SW-1:0] emit_k;
  logic [IW-1:0] iteration_count;
  logic          settled;

  // Datapath
  logic [DW-1:0] prev;
  logic [DW-1:0] cur;
  logic [1:0]    sum_hi;
  logic [DW-1:0] sum_lo;
  logic [DW-1:0] blur;
  logic          avg_pt;

  // Mesh store
  logic [DW-1:0] mesh [ebs_pkg::MAX_POINTS];
  logic [DW-1:0] rdata;
  logic          mem_re;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;

  ebs_pkg::mul_req_t      mul_req;
  logic [2*DW-1:0]        product;

  logic          accept;
  logic          store_full;
  logic [CW-1:0] count_next;
  logic          is_avg;
  logic          last_pt;
  logic          next_in_mesh;
  logic [IW-1:0] iter_next;
  logic [IW-1:0] limit_eff;
  logic          run_again;

  logic [DW-2:0] q0;
  logic [1:0]    r3;
  logic          carry3;
  logic [DW-1:0] hi_term;
  logic [DW-1:0] blur_avg;

  logic [DW-4:0] q1;
  logic [4:0]    rem18;
  logic [DW-1:0] scaled;
  logic [DW-1:0] diff;

  logic [ebs_pkg::DIV10_PW-1:0] le_prod;
  logic [ebs_pkg::DIV10_PW-1:0] rs_prod;

  ebs_mul u_mul (
    .clk     (clk),
    .req     (mul_req),
    .product (product)
  );

  // Load bookkeeping
  assign accept     = start && !busy;
  assign store_full = (point_count == CW'(ebs_pkg::MAX_POINTS));
  assign count_next = store_full ? point_count : point_count + CW'(1);

  // Band membership of the current point
  always_comb begin
    logic [CW:0] i_ext;
    i_ext  = (CW + 1)'(idx);
    is_avg = (n_pts >= CW'(3)) && (idx != '0) &&
             (i_ext + (CW + 1)'(2) <= (CW + 1)'(n_pts)) &&
             ((i_ext + (CW + 1)'(2) <= (CW + 1)'(left_end)) ||
              (i_ext + (CW + 1)'(1) >= (CW + 1)'(right_start)));
  end

  assign last_pt      = (CW'(idx) == n_pts - CW'(1));
  assign next_in_mesh = (CW'(idx) + CW'(1)) < n_pts;
  assign iter_next    = iteration_count + IW'(1);
  assign limit_eff    = (iteration_limit == '0) ? IW'(1) : iteration_limit;
  assign run_again    = !settled && (iter_next < limit_eff);

  // Band limits: n/10 and 9n/10
  assign le_prod = ebs_pkg::DIV10_PW'(n_pts) * ebs_pkg::DIV10_PW'(ebs_pkg::DIV10_M);
  assign rs_prod = (ebs_pkg::DIV10_PW'(n_pts) * ebs_pkg::DIV10_PW'(9)) *
                   ebs_pkg::DIV10_PW'(ebs_pkg::DIV10_M);

  // Finish floor(sum/3) from the product on the low word
  assign q0      = product[ebs_pkg::RECIP3_SHIFT +: DW-1];
  assign r3      = 2'(sum_lo[1:0] - 2'(3 * q0[1:0]));
  assign carry3  = (3'(sum_hi) + 3'(r3)) >= 3'd3;
  always_comb begin
    case (sum_hi)
      2'd1:    hi_term = ebs_pkg::DIV3_HI_UNIT;
      2'd2:    hi_term = ebs_pkg::DIV3_HI_UNIT << 1;
      default: hi_term = '0;
    endcase
  end
  assign blur_avg = hi_term + DW'(q0) + DW'(carry3);

  // Finish floor(blur*11/18) from floor(blur/18)
  assign q1     = product[ebs_pkg::RECIP9_SHIFT +: DW-3];
  assign rem18  = 5'(blur[4:0] - 5'(q1[4:0] * 5'd18));
  assign scaled = 32'(DW'(q1) * 32'd11) + DW'(ebs_pkg::scale_rem(rem18));

  assign diff = (blur > cur) ? blur - cur : cur - blur;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ebs_pkg::ST_IDLE:     if (accept && final_sample) state_next = ebs_pkg::ST_SETUP;
      ebs_pkg::ST_SETUP:    state_next = ebs_pkg::ST_PRIME;
      ebs_pkg::ST_PRIME:    state_next = ebs_pkg::ST_FETCH;
      ebs_pkg::ST_FETCH:    state_next = ebs_pkg::ST_SUM;
      ebs_pkg::ST_SUM:      state_next = is_avg ? ebs_pkg::ST_DIV3 : ebs_pkg::ST_MUL18;
      ebs_pkg::ST_DIV3:     state_next = ebs_pkg::ST_FIX3;
      ebs_pkg::ST_FIX3:     state_next = ebs_pkg::ST_MUL18;
      ebs_pkg::ST_MUL18:    state_next = ebs_pkg::ST_FIX18;
      ebs_pkg::ST_FIX18: begin
        if (!last_pt) begin
          state_next = ebs_pkg::ST_FETCH;
        end else if (run_again) begin
          state_next = ebs_pkg::ST_PRIME;
        end else begin
          state_next = ebs_pkg::ST_EMIT_RD;
        end
      end
      ebs_pkg::ST_EMIT_RD:  state_next = ebs_pkg::ST_EMIT_OUT;
      ebs_pkg::ST_EMIT_OUT: begin
        state_next = (emit_k == shown_last) ? ebs_pkg::ST_IDLE : ebs_pkg::ST_EMIT_RD;
      end
      default:              state_next = ebs_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    busy            = 1'b1;
    mem_re          = 1'b0;
    raddr           = idx + AW'(1);
    mem_we          = 1'b0;
    waddr           = idx;
    wdata           = scaled;
    mul_req.en      = 1'b0;
    mul_req.op      = ebs_pkg::MUL_DIV3;
    mul_req.operand = sum_lo;
    result_valid    = 1'b0;
    case (state)
      ebs_pkg::ST_IDLE: begin
        busy   = 1'b0;
        mem_we = accept && !store_full;
        waddr  = AW'(point_count);
        wdata  = sample;
      end
      ebs_pkg::ST_PRIME: begin
        mem_re = 1'b1;
        raddr  = '0;
      end
      ebs_pkg::ST_FETCH: begin
        mem_re = next_in_mesh;
      end
      ebs_pkg::ST_DIV3: begin
        mul_req.en = 1'b1;
      end
      ebs_pkg::ST_MUL18: begin
        mul_req.en      = 1'b1;
        mul_req.op      = ebs_pkg::MUL_DIV9;
        mul_req.operand = blur >> 1;
      end
      ebs_pkg::ST_FIX18: begin
        mem_we = 1'b1;
      end
      ebs_pkg::ST_EMIT_RD: begin
        mem_re = 1'b1;
        raddr  = AW'(emit_k);
      end
      ebs_pkg::ST_EMIT_OUT: begin
        result_valid = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Mesh store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mesh[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata <= mesh[raddr];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ebs_pkg::ST_IDLE;
      point_count      <= '0;
      iteration_count  <= '0;
      settled          <= 1'b1;
      settle_threshold <= ebs_pkg::SETTLE_THRESHOLD_RESET;
      iteration_limit  <= ebs_pkg::ITERATION_LIMIT_RESET;
    end else begin
      state <= state_next;

      // Take register writes
      if (cfg_write) begin
        case (cfg_index)
          ebs_pkg::REG_SETTLE_THRESHOLD: settle_threshold <= cfg_data;
          ebs_pkg::REG_ITERATION_LIMIT:  iteration_limit  <= cfg_data[IW-1:0];
          default: ;
        endcase
      end

      // Count loaded samples; a final sample closes the mesh
      if (accept) begin
        point_count <= final_sample ? '0 : count_next;
      end

      case (state)
        ebs_pkg::ST_SETUP: iteration_count <= '0;
        ebs_pkg::ST_PRIME: settled <= 1'b1;
        ebs_pkg::ST_MUL18: begin
          if (avg_pt && (diff > settle_threshold)) begin
            settled <= 1'b0;
          end
        end
        ebs_pkg::ST_FIX18: begin
          if (last_pt) begin
            iteration_count <= iter_next;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ebs_pkg::ST_IDLE: begin
        if (accept && final_sample) begin
          n_pts <= count_next;
        end
      end
      ebs_pkg::ST_SETUP: begin
        left_end    <= le_prod[ebs_pkg::DIV10_S +: CW];
        right_start <= rs_prod[ebs_pkg::DIV10_S +: CW];
        if (n_pts < CW'(ebs_pkg::SHOWN_POINTS)) begin
          shown_last <= SW'(n_pts - CW'(1));
        end else begin
          shown_last <= SW'(ebs_pkg::SHOWN_POINTS - 1);
        end
      end
      ebs_pkg::ST_PRIME: idx <= '0;
      ebs_pkg::ST_FETCH: begin
        // Slide the window: rdata holds the point now in hand
        prev <= cur;
        cur  <= rdata;
      end
      ebs_pkg::ST_SUM: begin
        avg_pt <= is_avg;
        {sum_hi, sum_lo} <= {2'b00, prev} + {2'b00, cur} + {2'b00, rdata};
        blur   <= cur;
      end
      ebs_pkg::ST_FIX3: blur <= blur_avg;
      ebs_pkg::ST_FIX18: begin
        if (last_pt) begin
          emit_k <= '0;
        end else begin
          idx <= idx + AW'(1);
        end
      end
      ebs_pkg::ST_EMIT_OUT: emit_k <= emit_k + SW'(1);
      default: ;
    endcase
  end

  // Result ports
  assign point_value     = rdata;
  assign point_index     = ebs_pkg::INDEX_W'(emit_k);
  assign iterations_done = iteration_count;
  assign converged       = settled;
  assign final_point     = (emit_k == shown_last);

`include "edge_blur_scale_stencil_assert.svh"

  `EBS_ASSERT_SAME(a_result_while_busy, clk, rst, result_valid, busy)
  `EBS_ASSERT_NEXT(a_idle_after_last, clk, rst, result_valid && final_point, !busy)
  `EBS_ASSERT_NEXT(a_plain_sample_stays_idle, clk, rst, start && !busy && !final_sample, !busy)
  `EBS_ASSERT_SAME(a_result_has_iteration, clk, rst, result_valid, iterations_done != '0)

endmodule

`default_nettype wire
